// File: src/hbw_pkg.sv
// Shared types and constants for the heartbeat toggle watchdog.
// Depends on nothing; imported by hbw_step and toggle_heartbeat_watchdog.
package hbw_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int THRESH_BITS  = 10;
    localparam int COUNT_BITS   = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 10;
    localparam int CMP_BITS     = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET  = THRESH_BITS'(900);
    localparam logic [COUNT_BITS-1:0]  TIMEOUT_RESET = COUNT_BITS'(40);
    localparam logic [COUNT_BITS-1:0]  GRACE_RESET   = COUNT_BITS'(40);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOGGLE_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRACE_TICKS     = 2'd2;

    typedef enum logic [1:0] {
        MODE_FAULT = 2'd0,
        MODE_OK    = 2'd1,
        MODE_GRACE = 2'd2
    } mode_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] level_threshold;
        logic [COUNT_BITS-1:0]  toggle_timeout;
        logic [COUNT_BITS-1:0]  grace_ticks;
    } hbw_cfg_t;

    typedef struct packed {
        mode_t                 mode;
        logic [COUNT_BITS-1:0] toggle_count;
        logic [COUNT_BITS-1:0] grace_count;
        logic                  prior_level;
        logic                  level_known;
        logic                  alarm_flag;
    } hbw_state_t;

    localparam hbw_state_t STATE_RESET = '{
        mode:         MODE_FAULT,
        toggle_count: '0,
        grace_count:  '0,
        prior_level:  1'b0,
        level_known:  1'b0,
        alarm_flag:   1'b1
    };

    typedef struct packed {
        mode_t link_state;
        logic  served;
        logic  bus_enable;
        logic  bus_off_signal;
        logic  alarm_on;
        logic  host_reset_pulse;
    } hbw_result_t;

endpackage

// File: src/hbw_step.sv
// One watchdog tick: threshold compare, toggle countdown and mode machine.
// Purely combinational; uses types from hbw_pkg.
module hbw_step (
    input  hbw_pkg::hbw_cfg_t                    cfg,
    input  hbw_pkg::hbw_state_t                  state,
    input  logic [hbw_pkg::SAMPLE_BITS-1:0]      sample,
    output hbw_pkg::hbw_state_t                  state_next,
    output hbw_pkg::hbw_result_t                 result
);
    import hbw_pkg::*;

    logic                  level;
    logic                  toggled;
    logic [COUNT_BITS-1:0] toggle_dec;
    logic [COUNT_BITS-1:0] toggle_new;
    logic                  is_served;
    logic [COUNT_BITS-1:0] grace_dec;
    logic                  bus_en;
    logic                  bus_off;
    logic                  pulse;

    // Derive level and the served countdown for this tick
    assign level      = CMP_BITS'(sample) > CMP_BITS'(cfg.level_threshold);
    assign toggled    = level != state.prior_level;
    assign toggle_dec = (state.toggle_count != '0) ? state.toggle_count - 1'b1
                                                   : state.toggle_count;
    assign toggle_new = toggled ? cfg.toggle_timeout : toggle_dec;
    assign is_served  = toggle_new != '0;
    assign grace_dec  = (state.grace_count != '0) ? state.grace_count - 1'b1
                                                  : state.grace_count;

    // Advance the mode machine
    always_comb begin
        state_next = state;
        bus_en     = 1'b0;
        bus_off    = 1'b1;
        pulse      = 1'b0;
        if (!state.level_known) begin
            // first tick only records the level
            state_next.prior_level = level;
            state_next.level_known = 1'b1;
            unique case (state.mode)
                MODE_OK:
                begin
                    bus_en  = 1'b1;
                    bus_off = 1'b0;
                end
                MODE_GRACE:
                begin
                    bus_en  = 1'b1;
                    bus_off = 1'b1;
                end
                default:
                begin
                    state_next.mode = MODE_FAULT;
                end
            endcase
        end else begin
            state_next.prior_level  = level;
            state_next.toggle_count = toggle_new;
            unique case (state.mode)
                MODE_OK:
                begin
                    bus_en  = 1'b1;
                    bus_off = 1'b0;
                    if (!is_served) begin
                        state_next.mode        = MODE_GRACE;
                        state_next.grace_count = cfg.grace_ticks;
                    end
                end
                MODE_GRACE:
                begin
                    bus_en  = 1'b1;
                    bus_off = 1'b1;
                    if (is_served) begin
                        state_next.mode = MODE_OK;
                    end else begin
                        state_next.grace_count = grace_dec;
                    end
                    if (state_next.grace_count == '0) begin
                        bus_en                = 1'b0;
                        state_next.alarm_flag = 1'b1;
                        pulse                 = 1'b1;
                        state_next.mode       = MODE_FAULT;
                    end
                end
                default:
                begin
                    state_next.mode = MODE_FAULT;
                    if (is_served) begin
                        state_next.alarm_flag = 1'b0;
                        state_next.mode       = MODE_OK;
                    end
                end
            endcase
        end
    end

    // Gather the pin levels after the step
    always_comb begin
        result.link_state       = state_next.mode;
        result.served           = state_next.toggle_count != '0;
        result.bus_enable       = bus_en;
        result.bus_off_signal   = bus_off;
        result.alarm_on         = state_next.alarm_flag;
        result.host_reset_pulse = pulse;
    end

endmodule

// File: src/toggle_heartbeat_watchdog.sv
// Top level of the heartbeat toggle watchdog: channels, registers, pipeline.
// Depends on hbw_pkg and hbw_step.
//
// Usage:
//   Each transfer on the input channel (in_valid/in_ready, level_sample) is one
//   time-slice tick. Each tick yields exactly one result on the output channel
//   (out_valid/out_ready): link_state, served, bus_enable, bus_off_signal,
//   alarm_on and host_reset_pulse, all levels after that tick.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   level_threshold (0), toggle_timeout (1) and grace_ticks (2); other indexes
//   are dropped. cfg_ready is always high; write only while the block is idle.
//   Path: an accepted tick is held in the input register, then its result is
//   presented from the result register until the receiver takes it.
//   Throughput: one tick per cycle while the receiver takes results; the
//   step logic between the two registers is combinational.
//   Reset: registers take 900/40/40, mode is fault with alarm on, counts zero,
//   and the next tick only records the heartbeat level.
//   When the receiver stalls the result holds; the input register still takes
//   one more tick, then in_ready drops until the result is taken.
module toggle_heartbeat_watchdog (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hbw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [hbw_pkg::CFG_DAT_BITS-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [hbw_pkg::SAMPLE_BITS-1:0]      level_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           link_state,
    output logic                                 served,
    output logic                                 bus_enable,
    output logic                                 bus_off_signal,
    output logic                                 alarm_on,
    output logic                                 host_reset_pulse
);
    import hbw_pkg::*;

    hbw_cfg_t                cfg_reg;
    hbw_state_t              state_reg;
    hbw_state_t              state_next;
    hbw_result_t             result_next;
    hbw_result_t             result_reg;
    logic                    s1_valid_reg;
    logic [SAMPLE_BITS-1:0]  s1_sample_reg;
    logic                    out_valid_reg;
    logic                    s1_advance;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.level_threshold <= THRESH_RESET;
            cfg_reg.toggle_timeout  <= TIMEOUT_RESET;
            cfg_reg.grace_ticks     <= GRACE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LEVEL_THRESHOLD: cfg_reg.level_threshold <= cfg_data[THRESH_BITS-1:0];
                REG_TOGGLE_TIMEOUT:  cfg_reg.toggle_timeout  <= cfg_data[COUNT_BITS-1:0];
                REG_GRACE_TICKS:     cfg_reg.grace_ticks     <= cfg_data[COUNT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Pipeline handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || !out_valid_reg || out_ready;

    // Hold the accepted sample in the input register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            s1_sample_reg <= level_sample;
        end
    end

    hbw_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .sample     (s1_sample_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Advance watchdog state and the result register together
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (s1_advance) begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign link_state       = result_reg.link_state;
    assign served           = result_reg.served;
    assign bus_enable       = result_reg.bus_enable;
    assign bus_off_signal   = result_reg.bus_off_signal;
    assign alarm_on         = result_reg.alarm_on;
    assign host_reset_pulse = result_reg.host_reset_pulse;

    // A reset pulse always lands in fault with the bus cut
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && host_reset_pulse) |-> (link_state == MODE_FAULT && !bus_enable))
        else $error("host reset pulse outside fault entry");

    // The bus is never enabled while the alarm is on
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bus_enable) |-> !alarm_on)
        else $error("bus enabled with alarm on");

    // The unused mode code never reaches the watchdog state
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == MODE_FAULT || state_reg.mode == MODE_OK
        || state_reg.mode == MODE_GRACE)
        else $error("illegal watchdog mode");

    // A tick that leaves the input register shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid)
        else $error("result lost after input register advance");

endmodule

// File: test/toggle_heartbeat_watchdog_test.sv
// Self-checking testbench for toggle_heartbeat_watchdog: directed table, then random
// heartbeat sequences under bursty input and a stalling receiver. Depends on hbw_pkg and the watchdog.
module toggle_heartbeat_watchdog_test;
    import hbw_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;
    localparam int RANDOM_TICKS = 1150;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  reg_index;
        logic [CFG_DAT_BITS-1:0]  value;
        logic                     typed;
        hbw_result_t              want;
    } step_row_t;

    localparam hbw_result_t UNCHECKED = '0;

    // Tick rows ignore reg_index; typed rows carry a hand-written result.
    localparam step_row_t DIRECTED [30] = '{
        // first tick after reset only records the level
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b1,
          '{MODE_FAULT, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        // toggle serves the host: fault to ok, bus still off this tick
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1023, 1'b1,
          '{MODE_OK, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd900, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd901, 1'b0, UNCHECKED},
        '{ROW_WRITE, REG_LEVEL_THRESHOLD, 10'd0, 1'b0, UNCHECKED},
        '{ROW_WRITE, REG_TOGGLE_TIMEOUT, 10'd1, 1'b0, UNCHECKED},
        '{ROW_WRITE, REG_GRACE_TICKS, 10'd2, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b0, UNCHECKED},
        // grace runs out: bus off, alarm and host reset
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b1,
          '{MODE_FAULT, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1023, 1'b0, UNCHECKED},
        // zero grace: the first tick in grace already expires
        '{ROW_WRITE, REG_GRACE_TICKS, 10'd0, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1023, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1, 1'b1,
          '{MODE_FAULT, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b0, UNCHECKED},
        // served in grace with zero grace count still expires
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1023, 1'b1,
          '{MODE_FAULT, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1}},
        // zero toggle timeout never serves
        '{ROW_WRITE, REG_TOGGLE_TIMEOUT, 10'd0, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1023, 1'b0, UNCHECKED},
        // unmapped index is dropped, upper data bits of counts are masked
        '{ROW_WRITE, REG_UNMAPPED, 10'd1023, 1'b0, UNCHECKED},
        '{ROW_WRITE, REG_TOGGLE_TIMEOUT, 10'h3FF, 1'b0, UNCHECKED},
        '{ROW_WRITE, REG_LEVEL_THRESHOLD, 10'd1023, 1'b0, UNCHECKED},
        '{ROW_WRITE, REG_GRACE_TICKS, 10'h3FF, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1023, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd512, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1022, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd0, 1'b0, UNCHECKED},
        '{ROW_TICK, REG_LEVEL_THRESHOLD, 10'd1023, 1'b0, UNCHECKED}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DAT_BITS-1:0] cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [SAMPLE_BITS-1:0]  level_sample;
    logic                    out_valid;
    logic                    out_ready;
    logic [1:0]              link_state;
    logic                    served;
    logic                    bus_enable;
    logic                    bus_off_signal;
    logic                    alarm_on;
    logic                    host_reset_pulse;

    hbw_state_t  wd_state;
    hbw_cfg_t    wd_cfg;
    hbw_result_t awaited_status [$];

    int   mismatch_count = 0;
    int   status_seen    = 0;
    int   burst_left     = 0;
    logic hb_level       = 1'b0;

    toggle_heartbeat_watchdog i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .level_sample     (level_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .link_state       (link_state),
        .served           (served),
        .bus_enable       (bus_enable),
        .bus_off_signal   (bus_off_signal),
        .alarm_on         (alarm_on),
        .host_reset_pulse (host_reset_pulse)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run if the block hangs
    initial
    begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // Advance the toggle countdown; reload it on a level change
    function automatic logic heartbeat_served(input logic lvl);
        if (wd_state.toggle_count != '0)
            wd_state.toggle_count = wd_state.toggle_count - 1'b1;
        if (lvl != wd_state.prior_level)
        begin
            wd_state.toggle_count = wd_cfg.toggle_timeout;
            wd_state.prior_level  = lvl;
        end
        return wd_state.toggle_count != '0;
    endfunction

    // Advance the watchdog by one tick and return the pin levels after it
    function automatic hbw_result_t watchdog_tick(input logic [SAMPLE_BITS-1:0] sample);
        logic        lvl;
        logic        bus_en;
        logic        bus_off;
        logic        pulse;
        hbw_result_t res;
        lvl   = sample > wd_cfg.level_threshold;
        pulse = 1'b0;
        if (!wd_state.level_known)
        begin
            // first tick: record the level, keep the mode's pins
            wd_state.prior_level = lvl;
            wd_state.level_known = 1'b1;
            bus_en  = wd_state.mode != MODE_FAULT;
            bus_off = wd_state.mode != MODE_OK;
        end
        else
        begin
            case (wd_state.mode)
                MODE_OK:
                begin
                    bus_en  = 1'b1;
                    bus_off = 1'b0;
                    if (!heartbeat_served(lvl))
                    begin
                        wd_state.mode        = MODE_GRACE;
                        wd_state.grace_count = wd_cfg.grace_ticks;
                    end
                end
                MODE_GRACE:
                begin
                    bus_en  = 1'b1;
                    bus_off = 1'b1;
                    if (heartbeat_served(lvl))
                        wd_state.mode = MODE_OK;
                    else if (wd_state.grace_count != '0)
                        wd_state.grace_count = wd_state.grace_count - 1'b1;
                    if (wd_state.grace_count == '0)
                    begin
                        bus_en              = 1'b0;
                        wd_state.alarm_flag = 1'b1;
                        pulse               = 1'b1;
                        wd_state.mode       = MODE_FAULT;
                    end
                end
                default:
                begin
                    bus_en  = 1'b0;
                    bus_off = 1'b1;
                    if (heartbeat_served(lvl))
                    begin
                        wd_state.alarm_flag = 1'b0;
                        wd_state.mode       = MODE_OK;
                    end
                end
            endcase
        end
        res.link_state       = wd_state.mode;
        res.served           = wd_state.toggle_count != '0;
        res.bus_enable       = bus_en;
        res.bus_off_signal   = bus_off;
        res.alarm_on         = wd_state.alarm_flag;
        res.host_reset_pulse = pulse;
        return res;
    endfunction

    // Pick a sample that lands on the requested side of the threshold
    function automatic logic [SAMPLE_BITS-1:0] sample_at(input logic lvl);
        int thr;
        thr = wd_cfg.level_threshold;
        if (lvl && thr < SAMPLE_MAX)
            return SAMPLE_BITS'($urandom_range(thr + 1, SAMPLE_MAX));
        if (lvl)
            return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        return SAMPLE_BITS'($urandom_range(0, thr));
    endfunction

    // Offer one tick in bursts with random gaps; predict it once transferred
    task automatic send_tick(input logic [SAMPLE_BITS-1:0] sample, input logic typed,
                             input hbw_result_t want);
        int          gap;
        hbw_result_t predicted;
        cfg_valid <= 1'b0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        level_sample <= sample;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        predicted = watchdog_tick(sample);
        awaited_status.push_back(typed ? want : predicted);
    endtask

    // Write one register once every outstanding result has come back
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DAT_BITS-1:0] data);
        in_valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_LEVEL_THRESHOLD: wd_cfg.level_threshold = data[THRESH_BITS-1:0];
            REG_TOGGLE_TIMEOUT:  wd_cfg.toggle_timeout  = data[COUNT_BITS-1:0];
            REG_GRACE_TICKS:     wd_cfg.grace_ticks     = data[COUNT_BITS-1:0];
            default:             ;
        endcase
    endtask

    // Stall the receiver in changing patterns, with one long hold-off
    initial
    begin
        int   chunk;
        int   style;
        int   hold_left;
        int   beat;
        bit   long_hold_done;
        hold_left      = 0;
        beat           = 0;
        long_hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            chunk = $urandom_range(16, 64);
            style = $urandom_range(0, 3);
            repeat (chunk)
            begin
                @(posedge clk);
                beat++;
                if (!long_hold_done && status_seen >= 400 && in_valid)
                begin
                    long_hold_done = 1'b1;
                    hold_left      = 120;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    case (style)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= $urandom_range(0, 1);
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= (beat % 3 == 0);
                    endcase
                end
            end
        end
    end

    // Check each transferred result against the oldest prediction
    always @(posedge clk)
    begin : watch_results
        hbw_result_t got;
        hbw_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{mode_t'(link_state), served, bus_enable, bus_off_signal, alarm_on,
                    host_reset_pulse};
            status_seen++;
            if (awaited_status.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none pending", status_seen));
            else
            begin
                want = awaited_status.pop_front();
                if (got.link_state != want.link_state)
                    report_mismatch($sformatf("result %0d link_state %0d, expected %0d",
                                              status_seen, got.link_state, want.link_state));
                if (got.served != want.served)
                    report_mismatch($sformatf("result %0d served %0b, expected %0b",
                                              status_seen, got.served, want.served));
                if (got.bus_enable != want.bus_enable)
                    report_mismatch($sformatf("result %0d bus_enable %0b, expected %0b",
                                              status_seen, got.bus_enable, want.bus_enable));
                if (got.bus_off_signal != want.bus_off_signal)
                    report_mismatch($sformatf("result %0d bus_off_signal %0b, expected %0b",
                                              status_seen, got.bus_off_signal,
                                              want.bus_off_signal));
                if (got.alarm_on != want.alarm_on)
                    report_mismatch($sformatf("result %0d alarm_on %0b, expected %0b",
                                              status_seen, got.alarm_on, want.alarm_on));
                if (got.host_reset_pulse != want.host_reset_pulse)
                    report_mismatch($sformatf("result %0d host_reset_pulse %0b, expected %0b",
                                              status_seen, got.host_reset_pulse,
                                              want.host_reset_pulse));
            end
        end
    end

    initial
    begin
        step_row_t row;
        int        sent;
        int        stop;
        int        seg;
        int        period;
        int        reps;
        int        len;
        int        thr;
        int        tmo;
        int        grc;
        int        drain;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_LEVEL_THRESHOLD;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        level_sample <= '0;
        wd_state = STATE_RESET;
        wd_cfg   = '{THRESH_RESET, TIMEOUT_RESET, GRACE_RESET};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_WRITE)
                write_register(row.reg_index, row.value);
            else
                send_tick(row.value[SAMPLE_BITS-1:0], row.typed, row.want);
        end

        // Random phases: new settings, then heartbeat runs, silences and noise
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = SAMPLE_MAX;
                2:       thr = THRESH_RESET;
                default: thr = $urandom_range(0, SAMPLE_MAX);
            endcase
            case ($urandom_range(0, 7))
                0:       tmo = 0;
                1:       tmo = 255;
                2, 3, 4: tmo = $urandom_range(1, 6);
                default: tmo = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 7))
                0:       grc = 0;
                1:       grc = 255;
                2, 3, 4: grc = $urandom_range(1, 6);
                default: grc = $urandom_range(0, 255);
            endcase
            write_register(REG_LEVEL_THRESHOLD, CFG_DAT_BITS'(thr));
            write_register(REG_TOGGLE_TIMEOUT, {2'($urandom_range(0, 3)), 8'(tmo)});
            write_register(REG_GRACE_TICKS, {2'($urandom_range(0, 3)), 8'(grc)});
            if ($urandom_range(0, 2) == 0)
                write_register(REG_UNMAPPED, CFG_DAT_BITS'($urandom));

            stop = sent + $urandom_range(60, 140);
            while (sent < stop)
            begin
                seg = $urandom_range(0, 9);
                if (seg <= 5)
                begin
                    // steady heartbeat, sometimes slower than the timeout
                    period = $urandom_range(1, (tmo > 22) ? 24 : tmo + 2);
                    reps   = $urandom_range(2, 10);
                    repeat (reps)
                    begin
                        hb_level = ~hb_level;
                        repeat (period)
                        begin
                            send_tick(sample_at(hb_level), 1'b0, UNCHECKED);
                            sent++;
                        end
                    end
                end
                else if (seg <= 7)
                begin
                    // heartbeat stops, sometimes long enough to fall into grace or fault
                    len = $urandom_range(1, (tmo + grc > 56) ? 60 : tmo + grc + 4);
                    repeat (len)
                    begin
                        send_tick(sample_at(hb_level), 1'b0, UNCHECKED);
                        sent++;
                    end
                end
                else
                begin
                    len = $urandom_range(1, 10);
                    repeat (len)
                    begin
                        send_tick(SAMPLE_BITS'($urandom), 1'b0, UNCHECKED);
                        sent++;
                    end
                end
            end
        end

        // Drain outstanding results, then allow for late extras
        in_valid <= 1'b0;
        drain = 0;
        while (awaited_status.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        if (awaited_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_status.size()));
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
src/hbw_pkg.sv
src/hbw_step.sv
src/toggle_heartbeat_watchdog.sv
test/toggle_heartbeat_watchdog_test.sv
